FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clk edge while arst_n is high
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every rising clk edge, also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/prbo_pkg.sv
// ---------------------------------------------------------------------------
// prbo_pkg
// Shared types and field widths of the overwriting packet ring buffer.
// ---------------------------------------------------------------------------
package prbo_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_DROP   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} kind_t;

	// one result beat as held in the output register
	typedef struct packed {
		logic              is_empty;
		logic [LEN_W-1:0]  length;
		logic              last;
		logic              has_byte;
		logic [BYTE_W-1:0] data;
		status_t           status;
	} result_t;

endpackage

FILE: rtl/prbo_ram.sv
// ---------------------------------------------------------------------------
// prbo_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module prbo_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/packet_ring_buffer_overwrite.sv
// ---------------------------------------------------------------------------
// packet_ring_buffer_overwrite
// Packet FIFO of SLOT_COUNT slots plus one staging slot; oldest packet is
// overwritten when a commit finds the FIFO full.
// ---------------------------------------------------------------------------
//  channel  dir  tdata (lsb up)                        tuser            tlast
//  s_*      in   in_byte[7:0] out_room[14:8]           kind             in_last
//  m_*      out  out_byte[7:0] beat_len[14:8]          status[1:0]      out_last
//                is_empty[15]                          has_byte[2]
//
// A push byte leaves the input open; a push with the last mark and an empty
// pop each load one beat into the output register at the accepting edge.
// A pop reads the slot length RAM (registered, used in S_LEN), then the byte
// RAM streams one byte per cycle, while the output is free, through a read
// stage; the input stays closed until the last byte leaves that stage.
// m_tready low stalls the byte stream without loss. Both RAMs start undefined:
// reset clears only the state, pointers, counters and flags, no clearing pass.
// ---------------------------------------------------------------------------
module packet_ring_buffer_overwrite #(
	parameter int SLOT_COUNT  = 16,
	parameter int PAYLOAD_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // in_byte[7:0], out_room[14:8]
	input  logic        s_tuser,   // kind
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte[7:0], beat_len[14:8], is_empty[15]
	output logic [2:0]  m_tuser,   // status[1:0], has_byte[2]
	output logic        m_tlast    // out_last
);

	import prbo_pkg::*;

	localparam int PHYS    = SLOT_COUNT + 1;
	localparam int SLOT_W  = $clog2(PHYS);
	localparam int COUNT_W = $clog2(SLOT_COUNT + 1);
	localparam int OFF_W   = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam int STORE_D = PHYS * PAYLOAD_MAX;
	localparam int ADDR_W  = $clog2(STORE_D);

	localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(PHYS - 1);
	localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(SLOT_COUNT);
	localparam logic [LEN_W-1:0]   PMAX_L    = LEN_W'(PAYLOAD_MAX);
	localparam logic [ADDR_W-1:0]  PMAX_A    = ADDR_W'(PAYLOAD_MAX);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LEN  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  wr_slot_q, rd_slot_q, pop_slot_q;
	logic [COUNT_W-1:0] count_q;
	logic [LEN_W-1:0]   asm_q;
	logic               ovf_q;
	logic [LEN_W-1:0]   room_q, len_q, idx_q;
	logic               s1_valid_q, s1_last_q;
	logic               out_valid_q;
	result_t            out_q;

	// input beat fields
	logic [BYTE_W-1:0] in_byte;
	logic [LEN_W-1:0]  in_room;
	kind_t             in_kind;

	assign in_byte = s_tdata[7:0];
	assign in_room = s_tdata[14:8];
	assign in_kind = kind_t'(s_tuser);

	logic out_free, in_acc, push_acc, pop_acc, store_byte;
	assign out_free   = !out_valid_q || m_tready;
	assign s_tready   = (state_q == S_IDLE) && out_free;
	assign in_acc     = s_tvalid && s_tready;
	assign push_acc   = in_acc && (in_kind == KIND_PUSH);
	assign pop_acc    = in_acc && (in_kind == KIND_POP);
	assign store_byte = push_acc && (asm_q < PMAX_L) && !ovf_q;

	// RAMs
	logic [BYTE_W-1:0] byte_rd;
	logic [LEN_W-1:0]  len_rd;
	logic              byte_rd_en, len_rd_en, len_wr_en;
	logic [ADDR_W-1:0] byte_wr_addr, byte_rd_addr;

	assign byte_wr_addr = ADDR_W'(wr_slot_q) * PMAX_A + ADDR_W'(asm_q[OFF_W-1:0]);
	assign byte_rd_addr = ADDR_W'(pop_slot_q) * PMAX_A + ADDR_W'(idx_q[OFF_W-1:0]);
	assign len_rd_en    = pop_acc && (count_q != '0);
	assign len_wr_en    = store_byte && s_tlast;

	prbo_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_D)) u_store (
		.clk     (clk),
		.wr_en   (store_byte),
		.wr_addr (byte_wr_addr),
		.wr_data (in_byte),
		.rd_en   (byte_rd_en),
		.rd_addr (byte_rd_addr),
		.rd_data (byte_rd)
	);

	prbo_ram #(.WIDTH(LEN_W), .DEPTH(PHYS)) u_len (
		.clk     (clk),
		.wr_en   (len_wr_en),
		.wr_addr (wr_slot_q),
		.wr_data (asm_q + LEN_W'(1)),
		.rd_en   (len_rd_en),
		.rd_addr (rd_slot_q),
		.rd_data (len_rd)
	);

	// length as read, clamped; drop when it does not fit the room or is zero
	logic [LEN_W-1:0] pop_len;
	logic             pop_drop;
	assign pop_len  = (len_rd > PMAX_L) ? PMAX_L : len_rd;
	assign pop_drop = (pop_len > room_q) || (pop_len == '0);

	logic s1_take;
	assign byte_rd_en = (state_q == S_EMIT) && (idx_q < len_q) && (!s1_valid_q || out_free);
	assign s1_take    = s1_valid_q && out_free;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_slot_q   <= '0;
			rd_slot_q   <= '0;
			count_q     <= '0;
			asm_q       <= '0;
			ovf_q       <= 1'b0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (push_acc) begin
						if (store_byte) begin
							asm_q <= asm_q + LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							asm_q       <= '0;
							ovf_q       <= 1'b0;
							out_valid_q <= 1'b1;
							if (store_byte) begin
								wr_slot_q <= slot_inc(wr_slot_q);
								if (count_q == FULL_CNT) begin
									rd_slot_q <= slot_inc(rd_slot_q);
								end else begin
									count_q <= count_q + COUNT_W'(1);
								end
							end
						end
					end else if (pop_acc) begin
						if (count_q == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							rd_slot_q <= slot_inc(rd_slot_q);
							count_q   <= count_q - COUNT_W'(1);
							state_q   <= S_LEN;
						end
					end
				end
				S_LEN: begin
					if (pop_drop) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (byte_rd_en) begin
						s1_valid_q <= 1'b1;
					end else if (s1_take) begin
						s1_valid_q <= 1'b0;
					end
					if (s1_take) begin
						out_valid_q <= 1'b1;
					end
					if ((idx_q == len_q) && !s1_valid_q) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop_acc) begin
			room_q     <= in_room;
			pop_slot_q <= rd_slot_q;
		end
		if (state_q == S_LEN) begin
			len_q <= pop_len;
			idx_q <= '0;
		end
		if (byte_rd_en) begin
			idx_q     <= idx_q + LEN_W'(1);
			s1_last_q <= (idx_q == len_q - LEN_W'(1));
		end

		if (push_acc && s_tlast) begin
			out_q.status   <= store_byte ? ST_OK : ST_REJECT;
			out_q.data     <= '0;
			out_q.has_byte <= 1'b0;
			out_q.last     <= 1'b1;
			out_q.length   <= store_byte ? asm_q + LEN_W'(1) : '0;
			out_q.is_empty <= store_byte ? 1'b0 : (count_q == '0);
		end else if (pop_acc && (count_q == '0)) begin
			out_q.status   <= ST_EMPTY;
			out_q.data     <= '0;
			out_q.has_byte <= 1'b0;
			out_q.last     <= 1'b1;
			out_q.length   <= '0;
			out_q.is_empty <= 1'b1;
		end else if ((state_q == S_LEN) && pop_drop && out_free) begin
			out_q.status   <= ST_DROP;
			out_q.data     <= '0;
			out_q.has_byte <= 1'b0;
			out_q.last     <= 1'b1;
			out_q.length   <= pop_len;
			out_q.is_empty <= (count_q == '0);
		end else if ((state_q == S_EMIT) && s1_take) begin
			out_q.status   <= ST_OK;
			out_q.data     <= byte_rd;
			out_q.has_byte <= 1'b1;
			out_q.last     <= s1_last_q;
			out_q.length   <= len_q;
			out_q.is_empty <= (count_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.is_empty, out_q.length, out_q.data};
	assign m_tuser  = {out_q.has_byte, out_q.status};
	assign m_tlast  = out_q.last;

	`include "assert_macros.svh"

	`ASSERT_CLK(a_count_max, count_q <= FULL_CNT, "stored count above slot count")
	`ASSERT_CLK(a_ptr_empty, (count_q == '0) == (rd_slot_q == wr_slot_q), "pointers vs count")
	`ASSERT_ALWAYS(a_s1_emit, s1_valid_q |-> (state_q == S_EMIT), "read stage valid outside emit")
	`ASSERT_CLK(a_idx_bound, (state_q == S_EMIT) |-> (idx_q <= len_q), "byte index past packet length")

endmodule

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for packet_ring_buffer_overwrite. A queue of requests
// (push bytes and pop requests) feeds a bursty stream driver; an untimed
// FIFO predictor turns every accepted beat into expected output beats, which
// a monitor compares field by field against m_* under a stalling receiver.
// ---------------------------------------------------------------------------
module tb;

	import prbo_pkg::*;

	localparam int SLOTS       = 16;
	localparam int PAYLOAD     = 64;
	localparam int PHYS        = SLOTS + 1;
	localparam int HOLD_CYCLES = 200;
	localparam int WDOG_LIMIT  = 5000;
	localparam int TAIL_CYCLES = 20;
	localparam int RAND_ITEMS  = 16;

	typedef struct {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [LEN_W-1:0]  room;
		bit                pause;   // hold this beat until all results are back
		bit                stall;   // receiver holds off once this beat goes out
	} req_t;

	typedef struct {
		result_t beat;
		int      stamp;
	} want_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // in_byte[7:0], out_room[14:8]
	logic        s_tuser  = 1'b0;  // kind
	logic        s_tlast  = 1'b0;  // in_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // out_byte[7:0], beat_len[14:8], is_empty[15]
	logic [2:0]  m_tuser;          // status[1:0], has_byte[2]
	logic        m_tlast;          // out_last

	req_t  req_q[$];
	want_t want_q[$];
	int    errors = 0;
	int    cyc = 0;
	int    n_req = 0;

	// predictor state
	logic [BYTE_W-1:0] pkt_mem [PHYS][PAYLOAD];
	int                pkt_len [PHYS];
	int                wr_slot = 0;
	int                rd_slot = 0;
	int                stored = 0;
	int                asm_cnt = 0;
	bit                asm_bad = 1'b0;

	// driver state
	req_t cur_req;
	bit   launch;
	int   burst_left = 1;
	int   gap_left = 0;
	logic hold_kick = 1'b0;

	// receiver state
	int hold_left = 0;
	int rx_cyc = 0;
	int rx_mode = 0;

	int    idle_cycles = 0;
	want_t mon_w;

	packet_ring_buffer_overwrite #(
		.SLOT_COUNT (SLOTS),
		.PAYLOAD_MAX(PAYLOAD)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	// ---------------- predictor ----------------

	function automatic void emit(status_t st, logic [BYTE_W-1:0] b, logic has, logic lst,
			int len);
		want_t w;
		w.beat.status   = st;
		w.beat.data     = b;
		w.beat.has_byte = has;
		w.beat.last     = lst;
		w.beat.length   = LEN_W'(len);
		w.beat.is_empty = (stored == 0);
		w.stamp         = cyc;
		want_q.push_back(w);
	endfunction

	task automatic fifo_step(input req_t r);
		int len;
		int base;
		begin
			if (r.kind == KIND_PUSH) begin
				if (asm_cnt < PAYLOAD && !asm_bad) begin
					pkt_mem[wr_slot][asm_cnt] = r.data;
					asm_cnt++;
				end else begin
					asm_bad = 1'b1;
				end
				if (r.last) begin
					if (asm_bad) begin
						asm_cnt = 0;
						asm_bad = 1'b0;
						emit(ST_REJECT, '0, 1'b0, 1'b1, 0);
					end else begin
						len = asm_cnt;
						pkt_len[wr_slot] = len;
						wr_slot = (wr_slot + 1) % PHYS;
						// full: the commit pushes the oldest packet out
						if (stored >= SLOTS)
							rd_slot = (rd_slot + 1) % PHYS;
						else
							stored++;
						asm_cnt = 0;
						emit(ST_OK, '0, 1'b0, 1'b1, len);
					end
				end
			end else if (stored == 0) begin
				emit(ST_EMPTY, '0, 1'b0, 1'b1, 0);
			end else begin
				len = pkt_len[rd_slot];
				base = rd_slot;
				rd_slot = (rd_slot + 1) % PHYS;
				stored--;
				if (len > r.room) begin
					emit(ST_DROP, '0, 1'b0, 1'b1, len);
				end else begin
					for (int i = 0; i < len; i++)
						emit(ST_OK, pkt_mem[base][i], 1'b1, i == len - 1, len);
				end
			end
		end
	endtask

	// ---------------- stimulus ----------------

	task automatic add_req(kind_t k, int b, bit lst, int room, bit pause, bit stall);
		req_t r;
		begin
			r.kind  = k;
			r.data  = BYTE_W'(b);
			r.last  = lst;
			r.room  = LEN_W'(room);
			r.pause = pause;
			r.stall = stall;
			req_q.push_back(r);
			n_req++;
		end
	endtask

	// n bytes of one packet; ends says whether the final one carries the last mark
	task automatic push_bytes(int n, bit ends);
		for (int i = 0; i < n; i++)
			add_req(KIND_PUSH, $urandom_range(0, 255), ends && (i == n - 1),
				$urandom_range(0, PAYLOAD), 1'b0, 1'b0);
	endtask

	// data and last are don't-care on a pop, so they carry noise
	task automatic add_pop(int room, bit pause, bit stall);
		add_req(KIND_POP, $urandom_range(0, 255), 1'($urandom_range(0, 1)), room, pause,
			stall);
	endtask

	initial begin
		int pick;
		int n;
		int k;
		int r;
		int rand_end;

		// directed opening
		add_pop(0, 1'b0, 1'b0);                                     // empty
		add_req(KIND_PUSH, 8'h00, 1'b1, PAYLOAD, 1'b0, 1'b0);
		add_req(KIND_PUSH, 8'hFF, 1'b0, 0, 1'b0, 1'b0);
		add_req(KIND_PUSH, 8'hA5, 1'b1, 0, 1'b0, 1'b0);
		add_pop(0, 1'b0, 1'b0);                                     // too small: drop
		add_req(KIND_PUSH, 8'h11, 1'b0, 0, 1'b0, 1'b0);
		add_pop(1, 1'b0, 1'b0);                                     // drop during assembly
		add_pop(PAYLOAD, 1'b0, 1'b0);                               // empty during assembly
		add_req(KIND_PUSH, 8'h22, 1'b1, PAYLOAD, 1'b0, 1'b0);
		add_pop(2, 1'b0, 1'b0);                                     // exact fit
		add_pop(PAYLOAD, 1'b0, 1'b0);
		add_req(KIND_PUSH, 8'h5A, 1'b1, PAYLOAD, 1'b0, 1'b0);
		add_pop(1, 1'b0, 1'b0);

		// full-size packet, then one byte oversize
		push_bytes(PAYLOAD, 1'b1);
		add_pop(PAYLOAD, 1'b0, 1'b0);
		push_bytes(PAYLOAD + 1, 1'b1);
		add_pop(PAYLOAD, 1'b0, 1'b0);

		// overrun the FIFO so the oldest packets get overwritten
		for (int i = 0; i < SLOTS + 2; i++)
			push_bytes(1, 1'b1);
		for (int i = 0; i < SLOTS + 1; i++)
			add_pop(PAYLOAD, 1'b0, 1'b0);

		// drain fully, then back-pressure while pops are streaming
		add_pop(PAYLOAD, 1'b1, 1'b0);
		for (int i = 0; i < 3; i++)
			push_bytes(4, 1'b1);
		add_pop(PAYLOAD, 1'b0, 1'b1);
		add_pop(PAYLOAD, 1'b0, 1'b0);
		add_pop(PAYLOAD, 1'b0, 1'b0);
		push_bytes(3, 1'b1);
		add_pop(PAYLOAD, 1'b0, 1'b0);

		// random traffic, mostly short packets and pops
		rand_end = n_req + RAND_ITEMS;
		while (n_req < rand_end) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				push_bytes($urandom_range(1, 8), 1'b1);
			end else if (pick < 58) begin
				push_bytes($urandom_range(9, 16), 1'b1);
			end else if (pick < 63) begin
				n = $urandom_range(2, 6);
				k = $urandom_range(1, n - 1);
				push_bytes(k, 1'b0);
				add_pop($urandom_range(0, PAYLOAD), 1'b0, 1'b0);
				push_bytes(n - k, 1'b1);
			end else begin
				r = $urandom_range(0, 9);
				if (r < 6)
					add_pop(PAYLOAD, 1'b0, 1'b0);
				else if (r < 8)
					add_pop($urandom_range(0, PAYLOAD), 1'b0, 1'b0);
				else
					add_pop($urandom_range(0, 8), 1'b0, 1'b0);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (req_q.size() != 0 || s_tvalid || want_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// ---------------- driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
			hold_kick <= 1'b0;
		end else begin
			launch = 1'b0;
			if (s_tvalid && s_tready)
				fifo_step(cur_req);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (req_q.size() != 0 && !(req_q[0].pause && want_q.size() != 0)) begin
					cur_req = req_q.pop_front();
					launch = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				s_tvalid <= launch;
				if (launch) begin
					s_tdata <= {1'b0, cur_req.room, cur_req.data};
					s_tuser <= cur_req.kind;
					s_tlast <= cur_req.last;
				end
			end
			hold_kick <= launch && cur_req.stall;
		end
	end

	// ---------------- receiver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			rx_cyc <= 0;
			rx_mode <= 0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if (rx_cyc % 64 == 0)
				rx_mode <= $urandom_range(0, 3);
			if (hold_kick)
				hold_left <= HOLD_CYCLES;
			else if (hold_left > 0)
				hold_left <= hold_left - 1;
			if (hold_kick || hold_left > 1) begin
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (rx_cyc % 5) < 3;
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// ---------------- monitor ----------------

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			// an expectation queued at this same edge cannot have been answered yet
			if (want_q.size() == 0 || want_q[0].stamp == cyc) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual tdata %0h tuser %0h tlast %0b",
					$time, m_tdata, m_tuser, m_tlast);
			end else begin
				mon_w = want_q.pop_front();
				check_field("status", int'(mon_w.beat.status), int'(m_tuser[1:0]));
				check_field("has_byte", int'(mon_w.beat.has_byte), int'(m_tuser[2]));
				check_field("out_byte", int'(mon_w.beat.data), int'(m_tdata[7:0]));
				check_field("beat_len", int'(mon_w.beat.length), int'(m_tdata[14:8]));
				check_field("is_empty", int'(mon_w.beat.is_empty), int'(m_tdata[15]));
				check_field("out_last", int'(mon_w.beat.last), int'(m_tlast));
			end
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/prbo_pkg.sv
rtl/prbo_ram.sv
rtl/packet_ring_buffer_overwrite.sv
dv/tb.sv
